// ===== hdl/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types, constants and the control store of the sorted table search.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned LEN_W           = 9;
  localparam int unsigned IDX_W           = 8;
  localparam int unsigned DATA_W          = 32;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_PROBE,
    ST_DONE
  } step_t;

  typedef enum logic [1:0] {
    JC_SEARCH,
    JC_STOP,
    JC_OUT_FREE
  } jcond_t;

  typedef struct packed {
    logic   in_rdy;
    logic   ld_init;
    logic   probe;
    logic   out_ld;
    jcond_t cond;
    step_t  tgt_t;
    step_t  tgt_f;
  } ctrl_t;

  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t w;
    case (step)
      ST_IDLE:  w = '{1'b1, 1'b0, 1'b0, 1'b0, JC_SEARCH,   ST_INIT, ST_IDLE};
      ST_INIT:  w = '{1'b0, 1'b1, 1'b0, 1'b0, JC_STOP,     ST_DONE, ST_PROBE};
      ST_PROBE: w = '{1'b0, 1'b0, 1'b1, 1'b0, JC_STOP,     ST_DONE, ST_PROBE};
      ST_DONE:  w = '{1'b0, 1'b0, 1'b0, 1'b1, JC_OUT_FREE, ST_IDLE, ST_DONE};
      default:  w = '{1'b0, 1'b0, 1'b0, 1'b0, JC_SEARCH,   ST_IDLE, ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/stbs_in_if.sv =====
// ----------------------------------------------------------------------------
// stbs_in_if
// Input channel: write or search transactions.
// ----------------------------------------------------------------------------
interface stbs_in_if import stbs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [IDX_W-1:0]         entry_index;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output command, output entry_index, output value,
                  input ready);
  modport sink   (input valid, input command, input entry_index, input value,
                  output ready);
endinterface

// ===== hdl/stbs_out_if.sv =====
// ----------------------------------------------------------------------------
// stbs_out_if
// Result channel: one transaction per search.
// ----------------------------------------------------------------------------
interface stbs_out_if import stbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface

// ===== hdl/sorted_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// A write is done when it is accepted. A search makes at most log2(length)+1
// probes, one table read per probe, and no new transaction is taken until it ends.
// The result sits in an output register; a new transaction is taken meanwhile.
// Reset clears the length register, sequencer and output valid; the table
// keeps its contents and is undefined until written.
// ----------------------------------------------------------------------------
module sorted_table_binary_search import stbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  stbs_in_if.sink          in_chan,
  stbs_out_if.source       out_chan
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned XW = (AW > LEN_W) ? AW : LEN_W;
  localparam int unsigned WW = (AW > IDX_W) ? AW : IDX_W;

  logic signed [DATA_W-1:0] mem [TABLE_DEPTH];

  logic [LEN_W-1:0]         len_cfg_r;
  logic [LEN_W-1:0]         len_eff;
  step_t                    upc_r, upc_nxt;
  ctrl_t                    ctl;
  logic                     cond_true;

  logic signed [DATA_W-1:0] key_r;
  logic signed [DATA_W-1:0] rdata_r;
  logic [LEN_W-1:0]         lo_r, lo_nxt;
  logic [LEN_W-1:0]         hi1_r, hi1_nxt;
  logic [LEN_W-1:0]         mid_r, mid_nxt;
  logic                     found_r, found_nxt;
  logic                     stop;
  logic                     rd_en;

  logic                     in_acc;
  logic                     wr_hit;
  logic                     eq, gt;
  logic [LEN_W:0]           sum_up, sum_dn;
  logic [LEN_W-1:0]         mid_up, mid_dn, init_mid;
  logic                     up_empty, dn_empty, init_empty;
  logic [XW-1:0]            rd_x;
  logic [AW-1:0]            rd_addr;
  logic [WW-1:0]            wr_x;
  logic [AW-1:0]            wr_addr;

  logic                     out_valid_r;
  logic                     out_found_r;
  logic [IDX_W-1:0]         out_pos_r;
  logic                     out_free;
  logic                     out_load;

  assign ctl           = ucode_rom(upc_r);
  assign in_chan.ready = ctl.in_rdy & rst_n;
  assign in_acc        = in_chan.valid & in_chan.ready;
  assign wr_hit        = in_acc & (in_chan.command == CMD_WRITE) &
                         (32'(in_chan.entry_index) < TABLE_DEPTH);

  assign len_eff = (32'(len_cfg_r) > TABLE_DEPTH) ? LEN_W'(TABLE_DEPTH) : len_cfg_r;

  assign eq         = (rdata_r == key_r);
  assign gt         = (rdata_r > key_r);
  assign sum_up     = {1'b0, mid_r} + {1'b0, hi1_r};
  assign mid_up     = sum_up[LEN_W:1];
  assign up_empty   = ({1'b0, mid_r} + (LEN_W+1)'(1)) >= {1'b0, hi1_r};
  assign sum_dn     = {1'b0, lo_r} + {1'b0, mid_r} - (LEN_W+1)'(1);
  assign mid_dn     = sum_dn[LEN_W:1];
  assign dn_empty   = (lo_r >= mid_r);
  assign init_mid   = (len_eff - LEN_W'(1)) >> 1;
  assign init_empty = (len_eff == '0);

  always_comb begin
    lo_nxt    = lo_r;
    hi1_nxt   = hi1_r;
    mid_nxt   = mid_r;
    found_nxt = found_r;
    stop      = 1'b0;
    rd_en     = 1'b0;
    if (ctl.ld_init) begin
      lo_nxt    = '0;
      hi1_nxt   = len_eff;
      mid_nxt   = init_mid;
      found_nxt = 1'b0;
      stop      = init_empty;
      rd_en     = !init_empty;
    end else if (ctl.probe) begin
      if (eq) begin
        found_nxt = 1'b1;
        stop      = 1'b1;
      end else if (gt) begin
        hi1_nxt = mid_r;
        mid_nxt = mid_dn;
        stop    = dn_empty;
        rd_en   = !dn_empty;
      end else begin
        lo_nxt  = mid_r + LEN_W'(1);
        mid_nxt = mid_up;
        stop    = up_empty;
        rd_en   = !up_empty;
      end
    end
  end

  assign rd_x    = XW'(mid_nxt);
  assign rd_addr = rd_x[AW-1:0];
  assign wr_x    = WW'(in_chan.entry_index);
  assign wr_addr = wr_x[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_addr] <= in_chan.value;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r <= in_chan.value;
    end
    lo_r    <= lo_nxt;
    hi1_r   <= hi1_nxt;
    mid_r   <= mid_nxt;
    found_r <= found_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= '0;
    end else if (cfg_we) begin
      len_cfg_r <= cfg_wdata;
    end
  end

  // sequencer: step register with conditional jump
  always_comb begin
    case (ctl.cond)
      JC_SEARCH:   cond_true = in_acc & (in_chan.command == CMD_SEARCH);
      JC_STOP:     cond_true = stop;
      JC_OUT_FREE: cond_true = out_free;
      default:     cond_true = 1'b0;
    endcase
    upc_nxt = cond_true ? ctl.tgt_t : ctl.tgt_f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ST_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign out_free = !out_valid_r | out_chan.ready;
  assign out_load = ctl.out_ld & out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= found_r;
      out_pos_r   <= found_r ? mid_r[IDX_W-1:0] : '0;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.found    = out_found_r;
  assign out_chan.position = out_pos_r;

endmodule

// ===== hdl/stbs_checker.sv =====
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks on the sorted table search, bound to the search block.
// ----------------------------------------------------------------------------
module stbs_checker import stbs_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_command,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_found,
  input logic [IDX_W-1:0] out_position
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_position))
    else $error("result changed while stalled");

  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_position == '0)
    else $error("miss with nonzero position");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_SEARCH |=> !in_ready)
    else $error("new transaction taken during search");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_command   (in_chan.command),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_found    (out_chan.found),
  .out_position (out_chan.position)
);

// ===== tb/sorted_table_binary_search_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_checker
// Watches the write/search, result and length ports of the table search,
// keeps its own copy of the table and the length, works out the answer of
// every search and compares each result transaction with the oldest one due.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_checker import stbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  stbs_in_if               in_mon,
  stbs_out_if              out_mon,
  output int unsigned      mismatch_count,
  output int unsigned      results_owed
);

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } hit_t;

  logic signed [DATA_W-1:0] table_mem [TABLE_DEPTH_DEF];
  logic [LEN_W-1:0]         table_len;
  hit_t                     expected_hits[$];

  function automatic hit_t lookup_key(input logic signed [DATA_W-1:0] key);
    hit_t hit;
    int   span;
    int   lo;
    int   hi;
    int   mid;
    hit  = '0;
    span = (table_len > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(table_len);
    lo   = 0;
    hi   = span - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (table_mem[mid] == key) begin
        hit.found    = 1'b1;
        hit.position = mid[IDX_W-1:0];
        return hit;
      end
      if (table_mem[mid] > key) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return hit;
  endfunction

  always @(posedge clk) begin
    hit_t want;
    if (!rst_n) begin
      table_len = '0;
      expected_hits.delete();
      mismatch_count = 0;
      results_owed = 0;
    end else begin
      if (cfg_we) begin
        table_len = cfg_wdata;
      end
      // retire before queuing, so a search taken this edge is never matched here
      if (out_mon.valid && out_mon.ready) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected result: found=%0b position=%0d",
                   $time, out_mon.found, out_mon.position);
          mismatch_count++;
        end else begin
          want = expected_hits.pop_front();
          if (out_mon.found !== want.found) begin
            $display("%0t: found mismatch: expected %0b, actual %0b",
                     $time, want.found, out_mon.found);
            mismatch_count++;
          end
          if (out_mon.position !== want.position) begin
            $display("%0t: position mismatch: expected %0d, actual %0d",
                     $time, want.position, out_mon.position);
            mismatch_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CMD_WRITE) begin
          table_mem[in_mon.entry_index] = in_mon.value;
        end else begin
          expected_hits.push_back(lookup_key(in_mon.value));
        end
      end
      results_owed = expected_hits.size();
    end
  end

endmodule

// ===== tb/sorted_table_binary_search_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_tb
// Loads ascending tables, sets the search length between phases and fires
// directed and random searches with random gaps on both channels; a checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_tb;
  import stbs_pkg::*;

  localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam int unsigned RANDOM_ITEMS  = 1100;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned QUIET_LIMIT   = 3000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;
  int unsigned      mismatch_count;
  int unsigned      results_owed;
  int unsigned      items_sent;
  int unsigned      quiet_cycles;
  bit               long_hold;
  bit               no_gaps;
  logic signed [DATA_W-1:0] shadow [TABLE_DEPTH_DEF];

  stbs_in_if  in_chan ();
  stbs_out_if out_chan ();

  sorted_table_binary_search dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sorted_table_binary_search_checker result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] val);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.command     <= cmd;
    in_chan.entry_index <= idx;
    in_chan.value       <= val;
    do @(posedge clk); while (!in_chan.ready);
    if (cmd == CMD_WRITE) begin
      shadow[idx] = val;
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_entry(input logic [IDX_W-1:0] idx, input logic signed [DATA_W-1:0] val);
    send_item(CMD_WRITE, idx, val);
  endtask

  task automatic search_key(input logic signed [DATA_W-1:0] key);
    send_item(CMD_SEARCH, IDX_W'($urandom), key);
  endtask

  // drain all results and let the block settle before touching the length
  task automatic set_length(input logic [LEN_W-1:0] len);
    in_chan.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wdata <= len;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_ascending(input int unsigned count);
    longint cur;
    longint stride;
    if ($urandom_range(0, 3) == 0) begin
      cur = longint'(KEY_MIN);
    end else begin
      cur = longint'($signed($urandom));
    end
    stride = (longint'(KEY_MAX) - cur) / count;
    stride = stride >> $urandom_range(0, 30);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count - 1 && $urandom_range(0, 3) == 0) begin
        cur = longint'(KEY_MAX);
      end
      write_entry(IDX_W'(i), DATA_W'(cur));
      cur += longint'($urandom_range(0, 32'(stride)));
    end
  endtask

  initial begin
    int unsigned gap_left;
    int unsigned open_left;
    gap_left  = 0;
    open_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end else if (open_left != 0) begin
        out_chan.ready <= 1'b1;
        open_left--;
      end else if (gap_left != 0) begin
        out_chan.ready <= 1'b0;
        gap_left--;
      end else begin
        out_chan.ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          open_left = $urandom_range(40, 160);
        end else begin
          gap_left = pick_gap();
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int unsigned span;
    int unsigned burst;
    int unsigned pick;
    int unsigned k;
    int unsigned random_start;
    logic signed [DATA_W-1:0] v;
    quiet_cycles        = 0;
    items_sent          = 0;
    long_hold           = 1'b0;
    no_gaps             = 1'b0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_chan.valid       = 1'b0;
    in_chan.command     = CMD_WRITE;
    in_chan.entry_index = '0;
    in_chan.value       = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero length after reset: nothing probed
    search_key(32'sd0);
    search_key(KEY_MIN);

    // ascending ramp with both extremes and a duplicate pair
    for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
      if (i == TABLE_DEPTH_DEF - 1) begin
        v = KEY_MAX;
      end else if (i == 101) begin
        v = 32'h8000_0000 + (32'd100 << 24);
      end else begin
        v = 32'h8000_0000 + (32'(i) << 24);
      end
      write_entry(IDX_W'(i), v);
    end
    set_length(LEN_W'(TABLE_DEPTH_DEF));
    search_key(KEY_MIN);
    search_key(KEY_MAX);
    search_key(32'sd0);
    search_key(32'h8000_0000 + (32'd100 << 24));
    search_key(KEY_MIN + 1);
    search_key(KEY_MAX - 1);
    search_key(32'sd5);

    // break the order, then restore it
    write_entry(8'd5, KEY_MAX);
    search_key(KEY_MAX);
    search_key(32'sh8500_0000);
    write_entry(8'd5, 32'sh8500_0000);

    // hold off the result side while searches keep coming
    long_hold = 1'b1;
    no_gaps   = 1'b1;
    repeat (24) search_key(shadow[$urandom_range(0, TABLE_DEPTH_DEF - 1)]);
    no_gaps = 1'b0;

    set_length(9'd1);
    search_key(KEY_MIN);
    search_key(32'sd0);
    // length past the table depth saturates
    set_length(9'h1FF);
    search_key(KEY_MAX);
    set_length(9'd2);
    search_key(KEY_MIN);
    search_key(32'sh8100_0000);

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       span = 0;
        1:       span = 1;
        2:       span = TABLE_DEPTH_DEF;
        3, 4, 5: span = $urandom_range(2, 16);
        default: span = $urandom_range(1, TABLE_DEPTH_DEF);
      endcase
      set_length(LEN_W'(span));
      no_gaps = ($urandom_range(0, 3) == 0);
      if (span != 0 && $urandom_range(0, 9) < 4) begin
        load_ascending(span);
      end
      burst = $urandom_range(20, 60);
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          k = $urandom_range(0, TABLE_DEPTH_DEF - 1);
          if (pick < 6 && k > 0 && k < TABLE_DEPTH_DEF - 1) begin
            v = DATA_W'((longint'(shadow[k-1]) + longint'(shadow[k+1])) / 2);
          end else begin
            v = $urandom;
          end
          write_entry(IDX_W'(k), v);
        end else if (span != 0 && pick < 65) begin
          search_key(shadow[$urandom_range(0, span - 1)]);
        end else if (span != 0 && pick < 80) begin
          v = shadow[$urandom_range(0, span - 1)];
          search_key($urandom_range(0, 1) ? v + 1 : v - 1);
        end else begin
          search_key($urandom);
        end
      end
    end
    no_gaps = 1'b0;

    in_chan.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
